// ----- hdl/mixed_fraction_alu_macros.svh -----
// ============================================================================
// Mixed fraction ALU assertion macros
// Shared forms for the concurrent checks on the block's ports.
// ============================================================================
`ifndef MIXED_FRACTION_ALU_MACROS_SVH
`define MIXED_FRACTION_ALU_MACROS_SVH

// Implication checked at every edge outside reset.
`define MFA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication checked outside reset.
`define MFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Non-overlapping implication checked, reset included.
`define MFA_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mfa_pkg.sv -----
// ============================================================================
// Mixed fraction ALU package
// Beat types, opcodes and the divider cell payload shared by all modules.
// ============================================================================
package mfa_pkg;

   localparam int FIELD_WIDTH           = 16;
   localparam int WORD_WIDTH            = 32;
   localparam int DIV_STEPS             = 64;
   localparam int OPERAND_WIDTH_DEFAULT = 16;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_CMP = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] a_whole;
      logic [15:0] a_numer;
      logic [15:0] a_denom;
      logic [15:0] b_whole;
      logic [15:0] b_numer;
      logic [15:0] b_denom;
   } mfa_req_type;

   typedef struct packed {
      logic [31:0] res_whole;
      logic [31:0] res_numer;
      logic [31:0] res_denom;
      logic        is_equal;
      logic        overflow;
   } mfa_rsp_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [63:0] num;
      logic [31:0] den;
      logic [31:0] quo;
      logic        sticky;
      logic [16:0] whole;
      logic [1:0]  op;
      logic        eq;
   } mfa_div_type;

endpackage

// ----- hdl/mfa_front.sv -----
// ============================================================================
// Mixed fraction ALU front end
// Three pipeline stages forming the products and the dividend and divisor.
// ============================================================================
module mfa_front
   import mfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        req_valid,
   input  mfa_req_type req_data,
   output logic        out_valid,
   output mfa_div_type out_data
);

   localparam int EFF_WIDTH = (OPERAND_WIDTH < FIELD_WIDTH) ? OPERAND_WIDTH : FIELD_WIDTH;
   localparam logic [FIELD_WIDTH-1:0] OPER_MASK =
      FIELD_WIDTH'((33'd1 << EFF_WIDTH) - 33'd1);

   logic [15:0] aw, an, ad, bw, bn, bd;

   logic        a_valid_ff, a_valid_in;
   logic [1:0]  a_op_ff;
   logic [15:0] a_an_ff, a_ad_ff, a_bn_ff, a_bd_ff;
   logic [16:0] a_wh_ff;
   logic [31:0] a_anbd_ff, a_bnad_ff, a_adbd_ff, a_awad_ff, a_bwbd_ff;

   logic        b_valid_ff;
   logic [1:0]  b_op_ff;
   logic [15:0] b_ad_ff, b_bd_ff;
   logic [31:0] b_ia_ff, b_ib_ff, b_de_ff, b_adbd_ff;
   logic [32:0] b_nu_ff;
   logic [16:0] b_wh_ff;

   logic        c_valid_ff;
   logic [1:0]  c_op_ff;
   logic [32:0] c_nu_ff;
   logic [31:0] c_de_ff, c_adbd_ff;
   logic [16:0] c_wh_ff;
   logic [63:0] c_prod_ff;
   logic [47:0] c_lhs_ff, c_rhs_ff;

   always_comb begin
      aw = req_data.a_whole & OPER_MASK;
      an = req_data.a_numer & OPER_MASK;
      ad = req_data.a_denom & OPER_MASK;
      bw = req_data.b_whole & OPER_MASK;
      bn = req_data.b_numer & OPER_MASK;
      bd = req_data.b_denom & OPER_MASK;
      if (ad == 16'd0) begin
         ad = 16'd1;
      end
      if (bd == 16'd0) begin
         bd = 16'd1;
      end
      a_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_op_ff   <= req_data.opcode;
         a_an_ff   <= an;
         a_ad_ff   <= ad;
         a_bn_ff   <= bn;
         a_bd_ff   <= bd;
         a_wh_ff   <= {1'b0, aw} + {1'b0, bw};
         a_anbd_ff <= {16'd0, an} * {16'd0, bd};
         a_bnad_ff <= {16'd0, bn} * {16'd0, ad};
         a_adbd_ff <= {16'd0, ad} * {16'd0, bd};
         a_awad_ff <= {16'd0, aw} * {16'd0, ad};
         a_bwbd_ff <= {16'd0, bw} * {16'd0, bd};

         b_op_ff   <= a_op_ff;
         b_ad_ff   <= a_ad_ff;
         b_bd_ff   <= a_bd_ff;
         b_ia_ff   <= a_awad_ff + {16'd0, a_an_ff};
         b_ib_ff   <= a_bwbd_ff + {16'd0, a_bn_ff};
         b_adbd_ff <= a_adbd_ff;
         b_wh_ff   <= a_wh_ff;
         if (a_ad_ff != a_bd_ff) begin
            b_nu_ff <= {1'b0, a_anbd_ff} + {1'b0, a_bnad_ff};
            b_de_ff <= a_adbd_ff;
         end else begin
            b_nu_ff <= {17'd0, a_an_ff} + {17'd0, a_bn_ff};
            b_de_ff <= {16'd0, a_ad_ff};
         end

         c_op_ff   <= b_op_ff;
         c_nu_ff   <= b_nu_ff;
         c_de_ff   <= b_de_ff;
         c_adbd_ff <= b_adbd_ff;
         c_wh_ff   <= b_wh_ff;
         c_prod_ff <= 64'(b_ia_ff) * 64'(b_ib_ff);
         c_lhs_ff  <= 48'(b_ia_ff) * 48'(b_bd_ff);
         c_rhs_ff  <= 48'(b_ib_ff) * 48'(b_ad_ff);
      end
   end

   always_comb begin
      out_valid       = c_valid_ff;
      out_data.rem    = 32'd0;
      out_data.quo    = 32'd0;
      out_data.sticky = 1'b0;
      out_data.op     = c_op_ff;
      out_data.eq     = (c_lhs_ff == c_rhs_ff);
      case (c_op_ff)
         OP_ADD: begin
            out_data.num   = {31'd0, c_nu_ff};
            out_data.den   = c_de_ff;
            out_data.whole = c_wh_ff;
         end
         OP_MUL: begin
            out_data.num   = c_prod_ff;
            out_data.den   = c_adbd_ff;
            out_data.whole = 17'd0;
         end
         default: begin
            out_data.num   = 64'd0;
            out_data.den   = 32'd1;
            out_data.whole = 17'd0;
         end
      endcase
   end

endmodule

// ----- hdl/mfa_div_cell.sv -----
// ============================================================================
// Mixed fraction ALU divider cell
// One restoring division step: brings in one dividend bit, yields one quotient bit.
// ============================================================================
module mfa_div_cell
   import mfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  mfa_div_type data_in,
   output logic        valid_ff,
   output mfa_div_type data_ff
);

   logic [32:0] trial;
   logic [32:0] diff;
   logic        take;
   mfa_div_type data_in_next;

   always_comb begin
      trial               = {data_in.rem, data_in.num[63]};
      diff                = trial - {1'b0, data_in.den};
      take                = (trial >= {1'b0, data_in.den});
      data_in_next        = data_in;
      data_in_next.rem    = take ? diff[31:0] : trial[31:0];
      data_in_next.num    = {data_in.num[62:0], 1'b0};
      data_in_next.quo    = {data_in.quo[30:0], take};
      data_in_next.sticky = data_in.sticky | data_in.quo[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in_next;
      end
   end

endmodule

// ----- hdl/mixed_fraction_alu.sv -----
// ============================================================================
// Mixed fraction ALU
// Adds, multiplies or compares two mixed fractions in a pipeline of
// three product stages, a row of division cells and an output register.
// ============================================================================
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  mfa_req_type
//  rsp_      out        rsp_valid/rsp_stall  mfa_rsp_type
//
// One beat is taken every cycle unless the result beat is stalled. Each beat
// passes three product stages, 64 division cells of one quotient bit each and
// one output stage; the division cells, one per dividend bit, set the latency.
// Reset clears the valid bits of every stage.
// While the output beat is stalled the whole pipeline holds and req_stall is high.
module mixed_fraction_alu
   import mfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mfa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mfa_rsp_type rsp_data
);

   logic        advance;
   logic        cell_valid [DIV_STEPS+1];
   mfa_div_type cell_data  [DIV_STEPS+1];
   mfa_div_type last;
   logic [32:0] whole_sum;
   logic        rsp_valid_ff;
   mfa_rsp_type rsp_data_ff, rsp_data_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   mfa_front #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_valid(req_valid),
      .req_data (req_data),
      .out_valid(cell_valid[0]),
      .out_data (cell_data[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      mfa_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_in(cell_valid[i]),
         .data_in (cell_data[i]),
         .valid_ff(cell_valid[i+1]),
         .data_ff (cell_data[i+1])
      );
   end

   always_comb begin
      last        = cell_data[DIV_STEPS];
      whole_sum   = {1'b0, last.quo} + {16'd0, last.whole};
      rsp_data_in = '0;
      rsp_data_in.res_denom = 32'd1;
      case (last.op)
         OP_ADD, OP_MUL: begin
            rsp_data_in.res_numer = last.rem;
            rsp_data_in.res_denom = last.den;
            if (last.sticky || whole_sum[32]) begin
               rsp_data_in.res_whole = {WORD_WIDTH{1'b1}};
               rsp_data_in.overflow  = 1'b1;
            end else begin
               rsp_data_in.res_whole = whole_sum[31:0];
            end
         end
         OP_CMP: begin
            rsp_data_in.is_equal = last.eq;
         end
         default: begin
            rsp_data_in.res_denom = 32'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cell_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/mfa_checker.sv -----
// ============================================================================
// Mixed fraction ALU checker
// Port-level checks on the input and result beats, bound to the top level.
// ============================================================================
`include "mixed_fraction_alu_macros.svh"

module mfa_checker
   import mfa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input mfa_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input mfa_rsp_type rsp_data
);

   `MFA_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data), "stalled input beat changed")
   `MFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed")
   `MFA_ASSERT_IMPL(a_ovf_sat, rsp_valid && rsp_data.overflow, rsp_data.res_whole == 32'hFFFFFFFF, "overflow without saturated whole part")
   `MFA_ASSERT_IMPL(a_numer_below, rsp_valid, rsp_data.res_numer < rsp_data.res_denom, "numerator not below denominator")
   `MFA_ASSERT_RESET(a_reset_empty, reset, !rsp_valid, "result beat after reset")

endmodule

bind mixed_fraction_alu mfa_checker u_mfa_checker (.*);
